// File: rtl/rhsm_pkg.sv
// ----------------------------------------------------------------------------
// rhsm_pkg
// Shared types and constants for the rolling-hash substring matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsm_pkg;

    // Default sizes, overridable on the top level
    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Fixed field widths
    localparam int BYTE_W        = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int LEN_W         = 5;
    localparam int POS_OUT_W     = 32;
    localparam int PATTERN_BYTES = 16;
    localparam int BYTE_SEL_W    = $clog2(PATTERN_BYTES);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    // Control from the configuration block to the match datapath
    typedef struct packed {
        logic             restart;   // config write: drop the current text
        logic [LEN_W-1:0] eff_len;   // clamped pattern length, 1..MAX_PATTERN
    } cfg_ctrl_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] match_position;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rolling_hash_substring_matcher.sv
// ----------------------------------------------------------------------------
// rolling_hash_substring_matcher
// Finds the first occurrence of a 1..16 byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle, sustained unless a full output register
// waits on m_tready; a byte is held in an input register, checked against
// the pattern across all window lanes in parallel, and its result (if any)
// lands in the output register that drives m_tvalid. Each text gives at most one
// transaction: found with the start index of the first match, or not-found
// on the tlast byte. Bytes after a match are swallowed up to tlast, which
// starts a new text. Write the configuration only while idle; any write to
// indexes 0 to 2 restarts the current text. The byte position saturates at
// 2^POSITION_BITS-1.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_hash_substring_matcher #(
    parameter int MAX_PATTERN   = rhsm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = rhsm_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [rhsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rhsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // text in
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rhsm_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] text_byte
    input  wire logic                                s_tlast,   // end_of_text
    // result out
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [rhsm_pkg::POS_OUT_W-1:0]           m_tdata,   // [31:0] match_position
    output logic                                     m_tuser    // [0] found
);

    rhsm_pkg::cfg_ctrl_t                          ctrl;
    logic [MAX_PATTERN-1:0][rhsm_pkg::BYTE_W-1:0] pat_lanes;

    logic                          in_valid_reg;
    logic [rhsm_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    rhsm_pkg::result_t             out_result_reg;

    logic                          step;
    logic                          res_valid;
    rhsm_pkg::result_t             result;

    rhsm_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .pat_lanes (pat_lanes)
    );

    // the held byte moves on once the output register is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    rhsm_match #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .pat_lanes   (pat_lanes),
        .step        (step),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .res_valid   (res_valid),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.match_position;
    assign m_tuser  = out_result_reg.found;

endmodule

`default_nettype wire

// File: rtl/rhsm_cfg.sv
// ----------------------------------------------------------------------------
// rhsm_cfg
// Configuration registers. Derives the clamped pattern length and the
// pattern bytes aligned to window lanes (lane 0 = last pattern byte).
// ----------------------------------------------------------------------------
`default_nettype none

module rhsm_cfg #(
    parameter int MAX_PATTERN = rhsm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         cfg_we,
    input  wire logic [rhsm_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input  wire logic [rhsm_pkg::CFG_DATA_W-1:0]              cfg_wdata,
    output rhsm_pkg::cfg_ctrl_t                               ctrl,
    output logic [MAX_PATTERN-1:0][rhsm_pkg::BYTE_W-1:0]      pat_lanes
);

    localparam int LEN_W = rhsm_pkg::LEN_W;

    logic [rhsm_pkg::CFG_DATA_W-1:0] low_reg, low_next;
    logic [rhsm_pkg::CFG_DATA_W-1:0] high_reg, high_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [LEN_W-1:0]                eff_len_reg, eff_len_next;
    logic [MAX_PATTERN-1:0][rhsm_pkg::BYTE_W-1:0] lanes_reg, lanes_next;
    logic [rhsm_pkg::PATTERN_BYTES-1:0][rhsm_pkg::BYTE_W-1:0] bytes_next;
    logic                            write_hit;

    always_comb begin
        write_hit = cfg_we && (cfg_index == rhsm_pkg::CFG_PATTERN_LOW ||
                               cfg_index == rhsm_pkg::CFG_PATTERN_HIGH ||
                               cfg_index == rhsm_pkg::CFG_PATTERN_LENGTH);
        low_next  = (cfg_we && cfg_index == rhsm_pkg::CFG_PATTERN_LOW)  ? cfg_wdata : low_reg;
        high_next = (cfg_we && cfg_index == rhsm_pkg::CFG_PATTERN_HIGH) ? cfg_wdata : high_reg;
        len_next  = (cfg_we && cfg_index == rhsm_pkg::CFG_PATTERN_LENGTH) ?
                    cfg_wdata[LEN_W-1:0] : len_reg;

        if (len_next == '0) begin
            eff_len_next = LEN_W'(1);
        end else if (len_next > LEN_W'(MAX_PATTERN)) begin
            eff_len_next = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len_next = len_next;
        end

        bytes_next = {high_next, low_next};
    end

    // lane j holds pattern byte eff_len-1-j; lanes at or above eff_len are unused
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
        logic [LEN_W-1:0] sel;
        assign sel = eff_len_next - LEN_W'(j) - LEN_W'(1);
        assign lanes_next[j] = (LEN_W'(j) < eff_len_next) ?
                               bytes_next[sel[rhsm_pkg::BYTE_SEL_W-1:0]] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg     <= '0;
            high_reg    <= '0;
            len_reg     <= LEN_W'(1);
            eff_len_reg <= LEN_W'(1);
            lanes_reg   <= '0;
        end else if (write_hit) begin
            low_reg     <= low_next;
            high_reg    <= high_next;
            len_reg     <= len_next;
            eff_len_reg <= eff_len_next;
            lanes_reg   <= lanes_next;
        end
    end

    assign ctrl.restart = write_hit;
    assign ctrl.eff_len = eff_len_reg;
    assign pat_lanes    = lanes_reg;

endmodule

`default_nettype wire

// File: rtl/rhsm_match.sv
// ----------------------------------------------------------------------------
// rhsm_match
// Per-text state: byte window, fill, position and done flag. Compares the
// updated window with the pattern lanes and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsm_match #(
    parameter int MAX_PATTERN   = rhsm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = rhsm_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire rhsm_pkg::cfg_ctrl_t                     ctrl,
    input  wire logic [MAX_PATTERN-1:0][rhsm_pkg::BYTE_W-1:0] pat_lanes,
    input  wire logic                                    step,
    input  wire logic [rhsm_pkg::BYTE_W-1:0]             text_byte,
    input  wire logic                                    end_of_text,
    output logic                                         res_valid,
    output rhsm_pkg::result_t                            result
);

    localparam int LEN_W  = rhsm_pkg::LEN_W;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int SUB_W  = (POSITION_BITS > rhsm_pkg::POS_OUT_W) ?
                            POSITION_BITS : rhsm_pkg::POS_OUT_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [MAX_PATTERN-1:0][rhsm_pkg::BYTE_W-1:0] win_reg, win_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     done_reg;
    logic [MAX_PATTERN-1:0]   lane_ok;
    logic                     hit;
    logic [SUB_W-1:0]         start_pos;

    always_comb begin
        win_next[0] = text_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_next[j] = win_reg[j-1];
        end
        fill_next = (fill_reg == FILL_W'(MAX_PATTERN)) ? fill_reg : fill_reg + FILL_W'(1);
        pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);

        // lanes beyond the pattern length always agree
        for (int j = 0; j < MAX_PATTERN; j++) begin
            lane_ok[j] = (LEN_W'(j) >= ctrl.eff_len) || (win_next[j] == pat_lanes[j]);
        end
        hit = !done_reg && (LEN_W'(fill_next) >= ctrl.eff_len) && (&lane_ok);

        start_pos = SUB_W'(pos_reg) - SUB_W'(ctrl.eff_len - LEN_W'(1));

        res_valid             = step && !done_reg && (hit || end_of_text);
        result.found          = hit;
        result.match_position = hit ? start_pos[rhsm_pkg::POS_OUT_W-1:0] : '0;
    end

    // window is payload: lanes are only compared once fill covers them
    always_ff @(posedge aclk) begin
        if (step && !done_reg) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.restart || (step && end_of_text)) begin
            fill_reg <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end else if (step && !done_reg) begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            done_reg <= hit;
        end
    end

endmodule

`default_nettype wire
